// ----- hdl/pdm_cic_decimator_top_macros.svh -----
// assertion macros used by the decimator top
`ifndef PDM_CIC_DECIMATOR_TOP_MACROS_SVH
`define PDM_CIC_DECIMATOR_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define PDM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define PDM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/pdm_cic_pkg.sv -----
package pdm_cic_pkg;

	// block geometry
	localparam int SAMPLES_PER_BLOCK = 32;
	localparam int SPB_W = $clog2(SAMPLES_PER_BLOCK);

	// field and state widths
	localparam int BPS_W = 5;
	localparam int DISC_W = 4;
	localparam int LEN_W = BPS_W + 1;
	localparam int DCOUNT_W = BPS_W + SPB_W;
	localparam int SAMPLE_W = 16;
	localparam int SUM_W = SAMPLE_W + SPB_W;
	localparam int PDM_W = 8;
	localparam int PCM_W = 8;
	localparam int CFG_IDX_W = 2;

	// register reset values
	localparam logic [BPS_W-1:0] BPS_RESET = 5'd8;
	localparam logic [DISC_W-1:0] DISC_RESET = 4'd6;

	// offset binary zero of the pcm output
	localparam logic [PCM_W-1:0] PCM_OFFSET = 8'd128;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DECIM_LEN      = 2'd0,
		REG_DISCARD_BLOCKS = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [BPS_W-1:0]  decim_len;
		logic [DISC_W-1:0] discard_blocks;
	} cfg_t;

	// one sample moving between stages
	typedef struct packed {
		logic                valid;
		logic [SAMPLE_W-1:0] value;
	} sample_t;

	// one pcm result ready for the output buffer
	typedef struct packed {
		logic             valid;
		logic [PCM_W-1:0] data;
	} pcm_t;

	// number of set bits in a byte, pairwise reduction
	function automatic logic [3:0] ones_in_byte(input logic [7:0] v);
		logic [7:0] pairs;
		logic [7:0] nibbles;
		pairs = (v & 8'h55) + ((v >> 1) & 8'h55);
		nibbles = (pairs & 8'h33) + ((pairs >> 2) & 8'h33);
		return nibbles[3:0] + nibbles[7:4];
	endfunction

endpackage

// ----- hdl/pdm_cic_front.sv -----
module pdm_cic_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  logic                               in_valid,
	input  logic [pdm_cic_pkg::PDM_W-1:0]      pdm_byte,
	input  pdm_cic_pkg::cfg_t                  cfg,
	output pdm_cic_pkg::sample_t               integ
);

	logic                                  valid_s1;
	logic [pdm_cic_pkg::PDM_W-1:0]         byte_s1;
	logic                                  valid_s2;
	logic [pdm_cic_pkg::SAMPLE_W-1:0]      integ_one_q;
	logic [pdm_cic_pkg::SAMPLE_W-1:0]      integ_two_q;
	logic [pdm_cic_pkg::BPS_W-1:0]         byte_idx_q;
	logic [pdm_cic_pkg::DISC_W-1:0]        blocks_q;
	logic [pdm_cic_pkg::DCOUNT_W-1:0]      dcount_q;

	logic [pdm_cic_pkg::LEN_W-1:0]         len;
	logic                                  discarding;
	logic [pdm_cic_pkg::DCOUNT_W:0]        dcount_next;
	logic [pdm_cic_pkg::DCOUNT_W:0]        dlimit;
	logic [3:0]                            pop;
	logic [4:0]                            delta;
	logic [pdm_cic_pkg::SAMPLE_W-1:0]      integ_one_next;
	logic [pdm_cic_pkg::SAMPLE_W-1:0]      integ_two_next;
	logic [pdm_cic_pkg::LEN_W-1:0]         idx_next;
	logic                                  sample_done;

	// sample length, discard test, popcount and integrator sums
	always_comb begin
		len = (cfg.decim_len == '0) ? pdm_cic_pkg::LEN_W'(1 << pdm_cic_pkg::BPS_W)
			: {1'b0, cfg.decim_len};
		discarding = blocks_q < cfg.discard_blocks;
		dcount_next = {1'b0, dcount_q} + 1'b1;
		dlimit = {len, pdm_cic_pkg::SPB_W'(0)};
		pop = pdm_cic_pkg::ones_in_byte(byte_s1);
		delta = {pop, 1'b0} - 5'd8;
		integ_one_next = integ_one_q + {{(pdm_cic_pkg::SAMPLE_W-5){delta[4]}}, delta};
		integ_two_next = integ_two_q + integ_one_next;
		idx_next = {1'b0, byte_idx_q} + 1'b1;
		sample_done = idx_next >= len;
	end

	// input byte register
	always_ff @(posedge clk) begin
		if (adv) begin
			byte_s1 <= pdm_byte;
		end
	end

	// discard counters, integrators and byte counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			integ_one_q <= '0;
			integ_two_q <= '0;
			byte_idx_q <= '0;
			blocks_q <= '0;
			dcount_q <= '0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= 1'b0;
			if (valid_s1) begin
				if (discarding) begin
					if (dcount_next >= dlimit) begin
						dcount_q <= '0;
						blocks_q <= blocks_q + 1'b1;
					end else begin
						dcount_q <= dcount_next[pdm_cic_pkg::DCOUNT_W-1:0];
					end
				end else begin
					integ_one_q <= integ_one_next;
					integ_two_q <= integ_two_next;
					if (sample_done) begin
						byte_idx_q <= '0;
						valid_s2 <= 1'b1;
					end else begin
						byte_idx_q <= idx_next[pdm_cic_pkg::BPS_W-1:0];
					end
				end
			end
		end
	end

	assign integ.valid = valid_s2;
	assign integ.value = integ_two_q;

endmodule

// ----- hdl/pdm_cic_comb.sv -----
module pdm_cic_comb (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  pdm_cic_pkg::sample_t  integ,
	output pdm_cic_pkg::sample_t  comb
);

	logic                              valid_s3;
	logic [pdm_cic_pkg::SAMPLE_W-1:0]  sample_s3;
	logic [pdm_cic_pkg::SAMPLE_W-1:0]  first_d0_q;
	logic [pdm_cic_pkg::SAMPLE_W-1:0]  first_d1_q;
	logic [pdm_cic_pkg::SAMPLE_W-1:0]  second_d0_q;
	logic [pdm_cic_pkg::SAMPLE_W-1:0]  second_d1_q;
	logic [pdm_cic_pkg::SAMPLE_W-1:0]  comb_a;

	// first comb stage, low bits are all that reach the sample
	assign comb_a = integ.value - first_d1_q;

	// comb delay lines and second comb stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			sample_s3 <= '0;
			first_d0_q <= '0;
			first_d1_q <= '0;
			second_d0_q <= '0;
			second_d1_q <= '0;
		end else if (adv) begin
			valid_s3 <= integ.valid;
			if (integ.valid) begin
				first_d1_q <= first_d0_q;
				first_d0_q <= integ.value;
				second_d1_q <= second_d0_q;
				second_d0_q <= comb_a;
				sample_s3 <= comb_a - second_d1_q;
			end
		end
	end

	assign comb.valid = valid_s3;
	assign comb.value = sample_s3;

endmodule

// ----- hdl/pdm_cic_dc.sv -----
module pdm_cic_dc (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  pdm_cic_pkg::sample_t  comb,
	output pdm_cic_pkg::pcm_t     push
);

	logic [pdm_cic_pkg::SUM_W-1:0]     block_sum_q;
	logic [pdm_cic_pkg::SAMPLE_W-1:0]  dc_avg_q;
	logic [pdm_cic_pkg::SPB_W-1:0]     sample_idx_q;

	logic [pdm_cic_pkg::SAMPLE_W-1:0]  adjusted;
	logic [pdm_cic_pkg::SUM_W-1:0]     sum_next;
	logic [pdm_cic_pkg::SUM_W-1:0]     bias;
	logic [pdm_cic_pkg::SUM_W-1:0]     rounded;
	logic [pdm_cic_pkg::SPB_W:0]       idx_next;
	logic                              block_end;

	// dc removal, block sum and average truncated toward zero
	always_comb begin
		adjusted = comb.value - dc_avg_q;
		sum_next = block_sum_q + {{pdm_cic_pkg::SPB_W{comb.value[pdm_cic_pkg::SAMPLE_W-1]}},
			comb.value};
		bias = sum_next[pdm_cic_pkg::SUM_W-1]
			? pdm_cic_pkg::SUM_W'(pdm_cic_pkg::SAMPLES_PER_BLOCK - 1) : '0;
		rounded = sum_next + bias;
		idx_next = {1'b0, sample_idx_q} + 1'b1;
		block_end = idx_next >= (pdm_cic_pkg::SPB_W+1)'(pdm_cic_pkg::SAMPLES_PER_BLOCK);
	end

	// block accumulation and average update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_sum_q <= '0;
			dc_avg_q <= '0;
			sample_idx_q <= '0;
		end else if (adv && comb.valid) begin
			if (block_end) begin
				block_sum_q <= '0;
				dc_avg_q <= rounded[pdm_cic_pkg::SUM_W-1:pdm_cic_pkg::SPB_W];
				sample_idx_q <= '0;
			end else begin
				block_sum_q <= sum_next;
				sample_idx_q <= idx_next[pdm_cic_pkg::SPB_W-1:0];
			end
		end
	end

	// scale to eight bits and shift to offset binary
	assign push.valid = comb.valid;
	assign push.data = adjusted[pdm_cic_pkg::PCM_W+1:2] + pdm_cic_pkg::PCM_OFFSET;

endmodule

// ----- hdl/pdm_cic_decimator_top.sv -----
// PDM to PCM decimator: second order CIC with block DC removal.
// Input channel in_valid/in_ready/pdm_byte: one transfer carries eight PDM bits.
// Output channel out_valid/out_ready/pcm_byte: one offset binary PCM byte per
// sample, one sample for every decim_len input bytes (32 when decim_len is 0).
// Config channel cfg_valid/cfg_ready/cfg_index/cfg_data: index 0 writes
// decim_len (bytes per sample), index 1 writes discard_blocks; other indexes
// are ignored. cfg_ready is always high; write only while the block is idle.
// Throughput: one input byte per cycle while the skid entry of the output buffer is free.
// Path: a byte that completes a sample reaches pcm_byte through the input byte
// register, the integrators and the comb, then dc removal into the output register.
// The first discard_blocks blocks of 32 samples worth of bytes are dropped.
// Reset clears filter state, counters and buffers and loads the register
// defaults (8 bytes per sample, 6 discarded blocks).
// When the receiver stalls, a two entry output buffer absorbs results;
// in_ready falls only once both entries are full, and the whole pipeline
// holds until the skid entry is free again.
`include "pdm_cic_decimator_top_macros.svh"

module pdm_cic_decimator_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [pdm_cic_pkg::PDM_W-1:0]       pdm_byte,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [pdm_cic_pkg::PCM_W-1:0]       pcm_byte,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pdm_cic_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pdm_cic_pkg::BPS_W-1:0]       cfg_data
);

	pdm_cic_pkg::cfg_t     cfg_q;
	pdm_cic_pkg::sample_t  integ;
	pdm_cic_pkg::sample_t  comb;
	pdm_cic_pkg::pcm_t     push;

	logic                             adv;
	logic                             out_free;
	logic                             stall_push;
	logic                             out_valid_q;
	logic [pdm_cic_pkg::PCM_W-1:0]    out_data_q;
	logic                             skid_valid_q;
	logic [pdm_cic_pkg::PCM_W-1:0]    skid_data_q;

	// pipeline moves whenever the skid entry is free
	assign adv = !skid_valid_q;
	assign in_ready = adv;
	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || out_ready;

	// a result arriving while the output register is held
	assign stall_push = push.valid && adv && !out_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.decim_len <= pdm_cic_pkg::BPS_RESET;
			cfg_q.discard_blocks <= pdm_cic_pkg::DISC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pdm_cic_pkg::REG_DECIM_LEN: begin
					cfg_q.decim_len <= cfg_data;
				end
				pdm_cic_pkg::REG_DISCARD_BLOCKS: begin
					cfg_q.discard_blocks <= cfg_data[pdm_cic_pkg::DISC_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	pdm_cic_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.pdm_byte (pdm_byte),
		.cfg      (cfg_q),
		.integ    (integ)
	);

	pdm_cic_comb u_comb (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.integ  (integ),
		.comb   (comb)
	);

	pdm_cic_dc u_dc (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.comb   (comb),
		.push   (push)
	);

	// output register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_free) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (out_free) begin
			out_valid_q <= push.valid;
		end else if (push.valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	// output buffer data
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_free) begin
				out_data_q <= skid_data_q;
			end
		end else if (out_free) begin
			out_data_q <= push.data;
		end else if (push.valid) begin
			skid_data_q <= push.data;
		end
	end

	assign out_valid = out_valid_q;
	assign pcm_byte = out_data_q;

	// output buffer checks
	`PDM_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full, output empty")
	`PDM_ASSERT_NEXT(a_stall_fills_skid, stall_push, skid_valid_q, "stalled result lost")
	`PDM_ASSERT_NEXT(a_skid_drains, skid_valid_q && out_ready, !skid_valid_q, "skid not drained")

endmodule

// ----- tb/sv/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// slack after the last sample: three pipeline stages plus the output buffer
	localparam int PIPE_SLACK = 8;
	localparam int SEG_ITEMS = 150;
	localparam int SEG_BPS[9] = '{4, 28, 0, 4, 5, 16, 4, 31, 12};
	localparam int SEG_DISC[9] = '{0, 1, 0, 2, 2, 0, 3, 0, 0};
	localparam logic [pdm_cic_pkg::CFG_IDX_W-1:0] UNUSED_REG_INDEX = 2'd3;
	localparam logic [7:0] EDGE_BYTES[16] = '{
		8'h00, 8'hFF, 8'h55, 8'hAA, 8'h33, 8'hCC, 8'h0F, 8'hF0,
		8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80
	};

	typedef enum {RUN_RANDOM, RUN_ONES, RUN_ZEROS, RUN_DENSITY} pdm_run_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [pdm_cic_pkg::PDM_W-1:0] pdm_byte = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [pdm_cic_pkg::PCM_W-1:0] pcm_byte;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [pdm_cic_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pdm_cic_pkg::BPS_W-1:0] cfg_data = '0;

	// pending pdm bytes and pcm samples still owed by the block
	logic [pdm_cic_pkg::PDM_W-1:0] pdm_pending[$];
	logic [pdm_cic_pkg::PCM_W-1:0] pcm_expected[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int bytes_queued = 0;
	int bytes_accepted = 0;
	int bytes_dropped = 0;
	int samples_checked = 0;
	int cfg_writes = 0;
	int fail_count = 0;

	// decimator state as the testbench sees it
	logic [pdm_cic_pkg::BPS_W-1:0] cfg_bps = pdm_cic_pkg::BPS_RESET;
	logic [pdm_cic_pkg::DISC_W-1:0] cfg_disc = pdm_cic_pkg::DISC_RESET;
	logic [31:0] integ_one = '0;
	logic [31:0] integ_two = '0;
	logic [31:0] comb1_hist[2] = '{32'd0, 32'd0};
	logic [31:0] comb2_hist[2] = '{32'd0, 32'd0};
	logic [31:0] block_acc = '0;
	logic [15:0] dc_avg = '0;
	int byte_cnt = 0;
	int sample_cnt = 0;
	logic [pdm_cic_pkg::DISC_W-1:0] blocks_dropped = '0;
	int drop_count = 0;

	pdm_cic_decimator_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pdm_byte(pdm_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pcm_byte(pcm_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// a length of zero wraps the counter to a full 32
	function automatic int sample_len();
		return (cfg_bps == '0) ? 32 : int'(cfg_bps);
	endfunction

	// start-up bytes still to be swallowed under the current settings
	function automatic int bytes_to_drop();
		if (cfg_disc > blocks_dropped)
			return int'(cfg_disc - blocks_dropped) * pdm_cic_pkg::SAMPLES_PER_BLOCK
				* sample_len() - drop_count;
		return 0;
	endfunction

	// one pdm byte through the cic, dc removal and offset; may owe a pcm sample
	function automatic void predict_pcm(input logic [pdm_cic_pkg::PDM_W-1:0] b);
		int len;
		logic [31:0] comb_a;
		logic [31:0] mag;
		logic [31:0] q;
		logic [15:0] sample;
		logic [15:0] adj;
		logic [pdm_cic_pkg::PCM_W-1:0] want;
		logic neg;
		len = sample_len();
		if (blocks_dropped < cfg_disc) begin
			bytes_dropped++;
			drop_count++;
			if (drop_count >= pdm_cic_pkg::SAMPLES_PER_BLOCK * len) begin
				drop_count = 0;
				blocks_dropped = blocks_dropped + 1'b1;
			end
			return;
		end
		integ_one = integ_one + 32'(2 * $countones(b)) - 32'd8;
		integ_two = integ_two + integ_one;
		byte_cnt++;
		if (byte_cnt < len)
			return;
		byte_cnt = 0;
		comb_a = integ_two - comb1_hist[1];
		comb1_hist[1] = comb1_hist[0];
		comb1_hist[0] = integ_two;
		sample = 16'(comb_a - comb2_hist[1]);
		comb2_hist[1] = comb2_hist[0];
		comb2_hist[0] = comb_a;
		block_acc = block_acc + {{16{sample[15]}}, sample};
		adj = sample - dc_avg;
		want = adj[9:2] + pdm_cic_pkg::PCM_OFFSET;
		pcm_expected.push_back(want);
		sample_cnt++;
		// end of block: new dc estimate, rounded toward zero
		if (sample_cnt >= pdm_cic_pkg::SAMPLES_PER_BLOCK) begin
			neg = block_acc[31];
			mag = neg ? (32'd0 - block_acc) : block_acc;
			q = mag / 32'(pdm_cic_pkg::SAMPLES_PER_BLOCK);
			dc_avg = 16'(neg ? (32'd0 - q) : q);
			block_acc = '0;
			sample_cnt = 0;
		end
	endfunction

	function automatic void flag_error(input string what,
			input logic [pdm_cic_pkg::PCM_W-1:0] want,
			input logic [pdm_cic_pkg::PCM_W-1:0] got);
		fail_count++;
		if (fail_count <= 10)
			$display("pcm error at %0t: %s, expected %02h, got %02h", $time, what, want, got);
	endfunction

	function automatic void push_byte(input logic [pdm_cic_pkg::PDM_W-1:0] b);
		pdm_pending.push_back(b);
		bytes_queued++;
	endfunction

	// runs of random, saturated and density-biased bytes
	task automatic queue_pdm(input int count);
		int run_left;
		int density;
		int pick;
		pdm_run_t run_kind;
		logic [pdm_cic_pkg::PDM_W-1:0] b;
		run_left = 0;
		density = 4;
		run_kind = RUN_RANDOM;
		repeat (count) begin
			if (run_left == 0) begin
				run_left = int'($urandom_range(64, 4));
				density = int'($urandom_range(8));
				pick = int'($urandom_range(9));
				if (pick < 4)
					run_kind = RUN_RANDOM;
				else if (pick == 4)
					run_kind = RUN_ONES;
				else if (pick == 5)
					run_kind = RUN_ZEROS;
				else
					run_kind = RUN_DENSITY;
			end
			run_left--;
			case (run_kind)
				RUN_ONES: b = 8'hFF;
				RUN_ZEROS: b = 8'h00;
				RUN_DENSITY: begin
					for (int k = 0; k < pdm_cic_pkg::PDM_W; k++)
						b[k] = ($urandom_range(7) < density);
				end
				default: b = 8'($urandom_range(255));
			endcase
			push_byte(b);
		end
	endtask

	// everything sent and every sample back, then let the pipeline settle
	task automatic drain();
		wait (bytes_accepted == bytes_queued && pcm_expected.size() == 0);
		repeat (PIPE_SLACK) @(posedge clk);
	endtask

	task automatic write_reg(input logic [pdm_cic_pkg::CFG_IDX_W-1:0] idx,
			input logic [pdm_cic_pkg::BPS_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			pdm_cic_pkg::REG_DECIM_LEN: cfg_bps = data;
			pdm_cic_pkg::REG_DISCARD_BLOCKS: cfg_disc = data[pdm_cic_pkg::DISC_W-1:0];
			default: ;
		endcase
		cfg_writes++;
	endtask

	// byte driver: predicts on every transfer, refills the channel from the queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			pdm_byte <= '0;
		end else begin
			if (in_valid && in_ready) begin
				predict_pcm(pdm_byte);
				bytes_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (pdm_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					pdm_byte <= pdm_pending.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// sample monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (pcm_expected.size() == 0) begin
					flag_error("sample with none outstanding", '0, pcm_byte);
				end else begin
					if (pcm_byte !== pcm_expected[0])
						flag_error("wrong sample", pcm_expected[0], pcm_byte);
					void'(pcm_expected.pop_front());
					samples_checked++;
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// stimulus sequence
	initial begin
		send_idle_pct = 33;
		recv_idle_pct = 52;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset defaults: one start-up block and part of the next dropped,
		// then discarding cut short and edge patterns at the default length
		write_reg(UNUSED_REG_INDEX, '1);
		queue_pdm(300);
		drain();
		write_reg(pdm_cic_pkg::REG_DISCARD_BLOCKS, 5'd1);
		foreach (EDGE_BYTES[i])
			push_byte(EDGE_BYTES[i]);
		drain();

		// a length of 28 left part way through a sample, then a length of 4
		write_reg(pdm_cic_pkg::REG_DECIM_LEN, 5'd28);
		queue_pdm(5);
		drain();
		write_reg(pdm_cic_pkg::REG_DECIM_LEN, 5'd4);
		queue_pdm(4);
		drain();

		// most start-up blocks, lowered again part way through a block
		write_reg(pdm_cic_pkg::REG_DISCARD_BLOCKS, 5'd15);
		queue_pdm(40);
		drain();
		write_reg(pdm_cic_pkg::REG_DISCARD_BLOCKS, 5'd0);

		// random segments across lengths and idle patterns
		for (int s = 0; s < 9; s++) begin
			if (s == 3) begin
				send_idle_pct = 52;
				recv_idle_pct = 33;
			end else if (s == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_reg(pdm_cic_pkg::REG_DECIM_LEN, 5'(SEG_BPS[s]));
			write_reg(pdm_cic_pkg::REG_DISCARD_BLOCKS, 5'(SEG_DISC[s]));
			queue_pdm(bytes_to_drop());
			queue_pdm(SEG_ITEMS);
			drain();
		end

		$display("run: %0d pdm bytes sent, %0d swallowed in start-up blocks, %0d register writes",
			bytes_accepted, bytes_dropped, cfg_writes);
		$display("run: %0d pcm samples checked over lengths 4 to 32, %0d errors",
			samples_checked, fail_count);
		if (fail_count == 0 && pcm_expected.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
